// ===== src/mluf_pkg.sv =====
package mluf_pkg;

    // bits of panel memory per pixel
    localparam int BITS_PER_PIXEL = 1;

    // configuration register indexes (word address = paddr[3:2])
    localparam logic [1:0] REG_ROTATION     = 2'd0;
    localparam logic [1:0] REG_LINE_PIXELS  = 2'd1;
    localparam logic [1:0] REG_COMMAND_BYTE = 2'd2;
    localparam int         PADDR_W          = 4;

    // rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // input item codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // result kinds, in the order they leave for one item
    typedef enum logic [2:0] {
        KIND_CMD  = 3'd0,
        KIND_ADDR = 3'd1,
        KIND_DATA = 3'd2,
        KIND_LTRL = 3'd3,
        KIND_FTRL = 3'd4
    } t_kind;

    // one bit per result kind; bit position equals the kind code
    localparam int MASK_W = 5;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  rotation;
        logic [10:0] line_pixels;
        logic [7:0]  command_byte;
    } t_cfg;

    // work handed from front to back: which results to emit and their payload
    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [7:0]        lead_byte;   // command byte or pixel byte
        logic [7:0]        addr_byte;   // bit-reversed line number plus one
        logic [7:0]        lo;          // first line, for the offset
        logic [7:0]        bpl;         // bytes per line, for the offset
    } t_job;

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

endpackage

// ===== src/mluf_queue.sv =====
module mluf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mluf_pkg::t_job       i_job,
    input  logic                 i_pop,
    output mluf_pkg::t_job       o_head,
    output logic                 o_full,
    output logic                 o_empty
);

    mluf_pkg::t_job                  r_mem [mluf_pkg::QUEUE_DEPTH];
    logic [mluf_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [mluf_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [mluf_pkg::QCNT_W-1:0]     r_count;
    logic                            w_do_push;
    logic                            w_do_pop;

    assign o_full    = (r_count == mluf_pkg::QCNT_W'(mluf_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_head    = r_mem[r_rd_ptr];

    // store entries
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + mluf_pkg::QPTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + mluf_pkg::QPTR_W'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + mluf_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - mluf_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/mluf_front.sv =====
module mluf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_cmd,
    input  logic                 i_dirty_flag,
    input  logic [7:0]           i_window_top,
    input  logic [7:0]           i_window_bottom,
    input  logic [7:0]           i_window_left,
    input  logic [7:0]           i_window_right,
    input  logic [7:0]           i_pixel_byte,
    input  mluf_pkg::t_cfg       i_cfg,
    output logic                 o_q_push,
    output mluf_pkg::t_job       o_q_job
);

    logic       r_frame_active, n_frame_active;
    logic [7:0] r_current_line, n_current_line;
    logic [8:0] r_lines_remaining, n_lines_remaining;
    logic [7:0] r_byte_in_line, n_byte_in_line;
    logic [7:0] r_line_bytes, n_line_bytes;

    logic [7:0]  w_a;
    logic [7:0]  w_b;
    logic [7:0]  w_lo;
    logic [7:0]  w_hi;
    logic [11:0] w_pw_round;
    logic [7:0]  w_bpl;
    logic [7:0]  w_bil_inc;
    logic [8:0]  w_lr_dec;

    // pick bounds by rotation and order them
    always_comb begin
        if (i_cfg.rotation inside {mluf_pkg::ROT_90, mluf_pkg::ROT_270}) begin
            w_a = i_window_left;
            w_b = i_window_right;
        end else begin
            w_a = i_window_top;
            w_b = i_window_bottom;
        end
        w_lo = (w_b < w_a) ? w_b : w_a;
        w_hi = (w_b < w_a) ? w_a : w_b;
    end

    // bytes per line, wrapped to 8 bits
    assign w_pw_round = {1'b0, i_cfg.line_pixels} + 12'd7;
    assign w_bpl      = 8'(w_pw_round[11:3] * mluf_pkg::BITS_PER_PIXEL);
    assign w_bil_inc  = r_byte_in_line + 8'd1;
    assign w_lr_dec   = r_lines_remaining - 9'd1;

    // classify the item and update frame state
    always_comb begin
        n_frame_active    = r_frame_active;
        n_current_line    = r_current_line;
        n_lines_remaining = r_lines_remaining;
        n_byte_in_line    = r_byte_in_line;
        n_line_bytes      = r_line_bytes;
        o_q_push          = 1'b0;
        o_q_job.mask      = '0;
        o_q_job.lead_byte = i_pixel_byte;
        o_q_job.addr_byte = mluf_pkg::reverse8(r_current_line + 8'd1);
        o_q_job.lo        = w_lo;
        o_q_job.bpl       = w_bpl;

        if (i_accept) begin
            if (i_cmd == mluf_pkg::CMD_START) begin
                n_frame_active    = 1'b0;
                n_byte_in_line    = '0;
                n_lines_remaining = '0;
                if (i_dirty_flag) begin
                    o_q_push          = 1'b1;
                    o_q_job.lead_byte = i_cfg.command_byte;
                    o_q_job.mask[mluf_pkg::KIND_CMD] = 1'b1;
                    n_line_bytes   = w_bpl;
                    n_current_line = w_lo;
                    if (w_bpl == '0) begin
                        // no bytes per line: close the frame at once
                        o_q_job.mask[mluf_pkg::KIND_FTRL] = 1'b1;
                    end else begin
                        n_frame_active    = 1'b1;
                        n_lines_remaining = {1'b0, w_hi} - {1'b0, w_lo} + 9'd1;
                    end
                end
            end else if (r_frame_active) begin
                o_q_push = 1'b1;
                o_q_job.mask[mluf_pkg::KIND_DATA] = 1'b1;
                if (r_byte_in_line == '0) begin
                    o_q_job.mask[mluf_pkg::KIND_ADDR] = 1'b1;
                end
                if (w_bil_inc >= r_line_bytes) begin
                    // end of line
                    o_q_job.mask[mluf_pkg::KIND_LTRL] = 1'b1;
                    n_byte_in_line    = '0;
                    n_current_line    = r_current_line + 8'd1;
                    n_lines_remaining = w_lr_dec;
                    if (w_lr_dec == '0) begin
                        o_q_job.mask[mluf_pkg::KIND_FTRL] = 1'b1;
                        n_frame_active = 1'b0;
                    end
                end else begin
                    n_byte_in_line = w_bil_inc;
                end
            end
        end
    end

    // hold frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_active    <= 1'b0;
            r_current_line    <= '0;
            r_lines_remaining <= '0;
            r_byte_in_line    <= '0;
            r_line_bytes      <= '0;
        end else begin
            r_frame_active    <= n_frame_active;
            r_current_line    <= n_current_line;
            r_lines_remaining <= n_lines_remaining;
            r_byte_in_line    <= n_byte_in_line;
            r_line_bytes      <= n_line_bytes;
        end
    end

endmodule

// ===== src/mluf_back.sv =====
module mluf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mluf_pkg::t_job       i_head,
    input  logic                 i_q_empty,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [7:0]           o_out_byte,
    output logic [2:0]           o_byte_kind,
    output logic [15:0]          o_start_offset,
    output logic                 o_frame_end,
    output logic                 o_last
);

    logic [mluf_pkg::MASK_W-1:0] r_done;
    logic [mluf_pkg::MASK_W-1:0] w_cur;
    logic [mluf_pkg::MASK_W-1:0] w_pick;
    logic [mluf_pkg::MASK_W-1:0] w_rest;
    mluf_pkg::t_kind             w_kind;
    logic                        w_advance;
    logic                        w_last;
    logic [7:0]                  w_byte;
    logic [15:0]                 w_offset;

    logic                        r_out_valid;
    logic [7:0]                  r_out_byte;
    mluf_pkg::t_kind             r_kind;
    logic [15:0]                 r_offset;
    logic                        r_last;

    // pick the next pending result of the head job
    assign w_cur  = i_head.mask & ~r_done;
    assign w_pick = w_cur & (~w_cur + mluf_pkg::MASK_W'(1));
    assign w_rest = w_cur & ~w_pick;
    assign w_last = (w_rest == '0);

    always_comb begin
        w_kind = mluf_pkg::KIND_CMD;
        for (int i = 0; i < mluf_pkg::MASK_W; i++) begin
            if (w_pick[i]) begin
                w_kind = mluf_pkg::t_kind'(i);
            end
        end
    end

    // build result payload
    always_comb begin
        w_offset = '0;
        case (w_kind)
            mluf_pkg::KIND_CMD: begin
                w_byte   = i_head.lead_byte;
                w_offset = {8'd0, i_head.lo} * {8'd0, i_head.bpl};
            end
            mluf_pkg::KIND_ADDR: w_byte = i_head.addr_byte;
            mluf_pkg::KIND_DATA: w_byte = i_head.lead_byte;
            default:             w_byte = '0;
        endcase
    end

    assign w_advance = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_pop   = w_advance && w_last;

    // track results already sent for the head job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
        end else if (w_advance) begin
            r_done <= w_last ? '0 : (r_done | w_pick);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_byte <= w_byte;
            r_kind     <= w_kind;
            r_offset   <= w_offset;
            r_last     <= w_last;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_byte_kind    = r_kind;
    assign o_start_offset = r_offset;
    assign o_frame_end    = (r_kind == mluf_pkg::KIND_FTRL);
    assign o_last         = r_last;

endmodule

// ===== src/memory_lcd_line_update_framer.sv =====
// Memory LCD multi-line write framer. Input items enter through a queue-style
// port (push/full): a start item opens a frame, pixel items fill it. Results
// leave one byte per cycle while pop is held, through a second queue-style port
// (empty/pop), each tagged with its kind (command, line address, pixel, line
// trailer, frame trailer). The front takes one item every cycle while its
// four-entry job queue has room; the back emits one result per cycle while pop
// is held, so most pixel items yield one result and a pixel item at a line
// boundary yields up to four (address, pixel, line trailer, frame trailer).
// Sustained rate is set by the back's single output register and the downstream
// pop rate. Registers (rotation at 0x0, line_pixels at 0x4, command_byte at 0x8)
// are written over the APB port and take effect at the next start item.
module memory_lcd_line_update_framer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mluf_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input items
    input  logic                          push,
    output logic                          full,
    input  logic                          i_cmd,
    input  logic                          i_dirty_flag,
    input  logic [7:0]                    i_window_top,
    input  logic [7:0]                    i_window_bottom,
    input  logic [7:0]                    i_window_left,
    input  logic [7:0]                    i_window_right,
    input  logic [7:0]                    i_pixel_byte,
    // results
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    o_out_byte,
    output logic [2:0]                    o_byte_kind,
    output logic [15:0]                   o_start_offset,
    output logic                          o_frame_end,
    output logic                          o_last
);

    mluf_pkg::t_cfg r_cfg;
    logic           w_cfg_wr;
    logic [1:0]     w_reg_idx;
    logic           w_accept;
    logic           w_q_push;
    mluf_pkg::t_job w_q_job;
    logic           w_q_pop;
    mluf_pkg::t_job w_q_head;
    logic           w_q_empty;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[3:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotation     <= 2'd0;
            r_cfg.line_pixels  <= 11'd128;
            r_cfg.command_byte <= 8'd192;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                mluf_pkg::REG_ROTATION:     r_cfg.rotation     <= pwdata[1:0];
                mluf_pkg::REG_LINE_PIXELS:  r_cfg.line_pixels  <= pwdata[10:0];
                mluf_pkg::REG_COMMAND_BYTE: r_cfg.command_byte <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (w_reg_idx)
            mluf_pkg::REG_ROTATION:     prdata = {30'd0, r_cfg.rotation};
            mluf_pkg::REG_LINE_PIXELS:  prdata = {21'd0, r_cfg.line_pixels};
            mluf_pkg::REG_COMMAND_BYTE: prdata = {24'd0, r_cfg.command_byte};
            default:                    prdata = '0;
        endcase
    end

    assign w_accept = push && !full;

    mluf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_cmd           (i_cmd),
        .i_dirty_flag    (i_dirty_flag),
        .i_window_top    (i_window_top),
        .i_window_bottom (i_window_bottom),
        .i_window_left   (i_window_left),
        .i_window_right  (i_window_right),
        .i_pixel_byte    (i_pixel_byte),
        .i_cfg           (r_cfg),
        .o_q_push        (w_q_push),
        .o_q_job         (w_q_job)
    );

    mluf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_q_job),
        .i_pop   (w_q_pop),
        .o_head  (w_q_head),
        .o_full  (full),
        .o_empty (w_q_empty)
    );

    mluf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_q_head),
        .i_q_empty      (w_q_empty),
        .o_q_pop        (w_q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_byte     (o_out_byte),
        .o_byte_kind    (o_byte_kind),
        .o_start_offset (o_start_offset),
        .o_frame_end    (o_frame_end),
        .o_last         (o_last)
    );

endmodule

// ===== src/mluf_checker.sv =====
module mluf_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          pready,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [7:0]                    o_out_byte,
    input  logic [2:0]                    o_byte_kind,
    input  logic [15:0]                   o_start_offset,
    input  logic                          o_frame_end,
    input  logic                          o_last
);

    // hold a waiting result until it is taken
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_byte_kind)))
        else $error("result changed before transfer");

    // frame trailer is a zero byte that closes its item
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_end) |->
        (o_byte_kind == mluf_pkg::KIND_FTRL && o_last && o_out_byte == 8'd0))
        else $error("bad frame trailer");

    // offset only rides on the command byte
    a_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_kind != mluf_pkg::KIND_CMD) |-> (o_start_offset == 16'd0))
        else $error("offset outside command byte");

    // line trailer is a zero byte
    a_line_trailer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_kind == mluf_pkg::KIND_LTRL) |-> (o_out_byte == 8'd0))
        else $error("nonzero line trailer");

    // nothing waits right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (empty && pready))
        else $error("result present after reset");

endmodule

bind memory_lcd_line_update_framer mluf_checker u_mluf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .pready         (pready),
    .empty          (empty),
    .pop            (pop),
    .o_out_byte     (o_out_byte),
    .o_byte_kind    (o_byte_kind),
    .o_start_offset (o_start_offset),
    .o_frame_end    (o_frame_end),
    .o_last         (o_last)
);

// ===== bench/lcd_frame_checker.sv =====
`timescale 1ns / 100ps

module lcd_frame_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration port, watched for register writes
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [mluf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    // input items
    input  logic                         push,
    input  logic                         full,
    input  logic                         i_cmd,
    input  logic                         i_dirty_flag,
    input  logic [7:0]                   i_window_top,
    input  logic [7:0]                   i_window_bottom,
    input  logic [7:0]                   i_window_left,
    input  logic [7:0]                   i_window_right,
    input  logic [7:0]                   i_pixel_byte,
    // results
    input  logic                         empty,
    input  logic                         pop,
    input  logic [7:0]                   o_out_byte,
    input  logic [2:0]                   o_byte_kind,
    input  logic [15:0]                  o_start_offset,
    input  logic                         o_frame_end,
    input  logic                         o_last,
    // to the testbench top
    output int                           o_mismatches,
    output int                           o_pending
);

    typedef struct {
        logic [7:0]      value;
        mluf_pkg::t_kind kind;
        logic [15:0]     offset;
        logic            frame_end;
        logic            last;
    } t_serial_byte;

    // bytes predicted but not yet seen on the result side
    t_serial_byte bytes_due[$];

    // register copies
    logic [1:0]  rot_cfg;
    logic [10:0] width_cfg;
    logic [7:0]  cmd_cfg;

    // framing state
    logic        frame_open;
    logic [7:0]  line_no;
    logic [8:0]  lines_left;
    logic [7:0]  byte_pos;
    logic [7:0]  line_len;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic t_serial_byte make_byte(input logic [7:0] value,
                                               input mluf_pkg::t_kind kind,
                                               input logic [15:0] offset, input logic fend);
        t_serial_byte sb;
        sb.value     = value;
        sb.kind      = kind;
        sb.offset    = offset;
        sb.frame_end = fend;
        sb.last      = 1'b0;
        return sb;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        o_mismatches++;
    endtask

    // work out the serial bytes that one accepted item causes
    task automatic predict_frame_bytes();
        t_serial_byte made[4];
        int           n;
        logic [7:0]   lo;
        logic [7:0]   hi;
        logic [7:0]   tmp;
        logic [7:0]   bpl;
        logic [7:0]   nxt;
        logic [7:0]   addr;
        int unsigned  bytes_wide;
        n = 0;
        if (i_cmd == mluf_pkg::CMD_START) begin
            // any start drops the frame in progress
            frame_open = 1'b0;
            byte_pos   = '0;
            lines_left = '0;
            if (i_dirty_flag) begin
                if (rot_cfg inside {mluf_pkg::ROT_90, mluf_pkg::ROT_270}) begin
                    lo = i_window_left;
                    hi = i_window_right;
                end else begin
                    lo = i_window_top;
                    hi = i_window_bottom;
                end
                if (hi < lo) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                bytes_wide = (int'(width_cfg) + 7) / 8 * mluf_pkg::BITS_PER_PIXEL;
                bpl        = bytes_wide[7:0];
                line_len   = bpl;
                line_no    = lo;
                made[n] = make_byte(cmd_cfg, mluf_pkg::KIND_CMD, {8'd0, lo} * {8'd0, bpl},
                                    1'b0);
                n++;
                if (bpl == 0) begin
                    made[n] = make_byte(8'd0, mluf_pkg::KIND_FTRL, 16'd0, 1'b1);
                    n++;
                end else begin
                    frame_open = 1'b1;
                    lines_left = {1'b0, hi} - {1'b0, lo} + 9'd1;
                end
            end
        end else if (frame_open) begin
            // line address ahead of the first byte of a line
            if (byte_pos == 0) begin
                nxt = line_no + 8'd1;
                for (int k = 0; k < 8; k++) begin
                    addr[k] = nxt[7-k];
                end
                made[n] = make_byte(addr, mluf_pkg::KIND_ADDR, 16'd0, 1'b0);
                n++;
            end
            made[n] = make_byte(i_pixel_byte, mluf_pkg::KIND_DATA, 16'd0, 1'b0);
            n++;
            byte_pos = byte_pos + 8'd1;
            if (byte_pos >= line_len) begin
                made[n] = make_byte(8'd0, mluf_pkg::KIND_LTRL, 16'd0, 1'b0);
                n++;
                byte_pos   = '0;
                line_no    = line_no + 8'd1;
                lines_left = lines_left - 9'd1;
                if (lines_left == 0) begin
                    made[n] = make_byte(8'd0, mluf_pkg::KIND_FTRL, 16'd0, 1'b1);
                    n++;
                    frame_open = 1'b0;
                end
            end
        end
        if (n > 0) begin
            made[n-1].last = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            bytes_due.push_back(made[k]);
        end
    endtask

    // compare one transfer on the result side with the oldest prediction
    task automatic check_serial_byte();
        t_serial_byte due;
        if (bytes_due.size() == 0) begin
            report_mismatch($sformatf("result with nothing due (kind %0d)", o_byte_kind),
                            -1, o_out_byte);
        end else begin
            due = bytes_due.pop_front();
            if (o_byte_kind !== due.kind)
                report_mismatch("byte_kind", due.kind, o_byte_kind);
            if (o_out_byte !== due.value)
                report_mismatch("out_byte", due.value, o_out_byte);
            if (o_start_offset !== due.offset)
                report_mismatch("start_offset", due.offset, o_start_offset);
            if (o_frame_end !== due.frame_end)
                report_mismatch("frame_end", due.frame_end, o_frame_end);
            if (o_last !== due.last)
                report_mismatch("last", due.last, o_last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rot_cfg    = mluf_pkg::ROT_0;
            width_cfg  = 11'd128;
            cmd_cfg    = 8'd192;
            frame_open = 1'b0;
            line_no    = '0;
            lines_left = '0;
            byte_pos   = '0;
            line_len   = '0;
            bytes_due.delete();
        end else begin
            // track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    mluf_pkg::REG_ROTATION:     rot_cfg   = pwdata[1:0];
                    mluf_pkg::REG_LINE_PIXELS:  width_cfg = pwdata[10:0];
                    mluf_pkg::REG_COMMAND_BYTE: cmd_cfg   = pwdata[7:0];
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                check_serial_byte();
            end
            if (push && !full) begin
                predict_frame_bytes();
            end
        end
        o_pending <= bytes_due.size();
    end

endmodule

// ===== bench/memory_lcd_line_update_framer_test.sv =====
`timescale 1ns / 100ps

module memory_lcd_line_update_framer_test;

    localparam int QUIET_LIMIT    = 3000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLDOFF_CYCLES = 300;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [mluf_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         push = 1'b0;
    logic                         full;
    logic                         i_cmd = mluf_pkg::CMD_START;
    logic                         i_dirty_flag = 1'b0;
    logic [7:0]                   i_window_top = '0;
    logic [7:0]                   i_window_bottom = '0;
    logic [7:0]                   i_window_left = '0;
    logic [7:0]                   i_window_right = '0;
    logic [7:0]                   i_pixel_byte = '0;
    logic                         empty;
    logic                         pop = 1'b0;
    logic [7:0]                   o_out_byte;
    logic [2:0]                   o_byte_kind;
    logic [15:0]                  o_start_offset;
    logic                         o_frame_end;
    logic                         o_last;

    int mismatches;
    int results_due;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holdoff_asked = 0;
    int holdoff_served = 0;
    int items_sent = 0;
    int line_len_now = 0;

    always #1 i_clk = ~i_clk;

    memory_lcd_line_update_framer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .push           (push),
        .full           (full),
        .i_cmd          (i_cmd),
        .i_dirty_flag   (i_dirty_flag),
        .i_window_top   (i_window_top),
        .i_window_bottom(i_window_bottom),
        .i_window_left  (i_window_left),
        .i_window_right (i_window_right),
        .i_pixel_byte   (i_pixel_byte),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_byte_kind    (o_byte_kind),
        .o_start_offset (o_start_offset),
        .o_frame_end    (o_frame_end),
        .o_last         (o_last)
    );

    lcd_frame_checker u_frame_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .push           (push),
        .full           (full),
        .i_cmd          (i_cmd),
        .i_dirty_flag   (i_dirty_flag),
        .i_window_top   (i_window_top),
        .i_window_bottom(i_window_bottom),
        .i_window_left  (i_window_left),
        .i_window_right (i_window_right),
        .i_pixel_byte   (i_pixel_byte),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_byte_kind    (o_byte_kind),
        .o_start_offset (o_start_offset),
        .o_frame_end    (o_frame_end),
        .o_last         (o_last),
        .o_mismatches   (mismatches),
        .o_pending      (results_due)
    );

    // result side: random stalls, plus a long hold-off when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (holdoff_asked != holdoff_served) begin
                pop <= 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(negedge i_clk);
                holdoff_served++;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // end the run when no transfer happens on either side for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    // offer one item and hold it until the transfer
    task automatic send_item(input logic cmd, input logic dirty, input logic [7:0] top,
                             input logic [7:0] bottom, input logic [7:0] left,
                             input logic [7:0] right, input logic [7:0] px, input bit counted);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push            <= 1'b1;
        i_cmd           <= cmd;
        i_dirty_flag    <= dirty;
        i_window_top    <= top;
        i_window_bottom <= bottom;
        i_window_left   <= left;
        i_window_right  <= right;
        i_pixel_byte    <= px;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (counted) items_sent++;
    endtask

    task automatic send_start(input logic dirty, input logic [7:0] top, input logic [7:0] bottom,
                              input logic [7:0] left, input logic [7:0] right);
        send_item(mluf_pkg::CMD_START, dirty, top, bottom, left, right, 8'($urandom), 1'b1);
    endtask

    task automatic send_pixel(input logic [7:0] px, input bit counted);
        send_item(mluf_pkg::CMD_PIXEL, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), px, counted);
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drop push, drain every due result, then give the block time to go idle
    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        while (results_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] rot, input logic [10:0] width,
                            input logic [7:0] cmd_byte, input int send_pct, input int recv_pct);
        int unsigned bytes_wide;
        settle();
        apb_write(mluf_pkg::REG_ROTATION, {30'd0, rot});
        apb_write(mluf_pkg::REG_LINE_PIXELS, {21'd0, width});
        apb_write(mluf_pkg::REG_COMMAND_BYTE, {24'd0, cmd_byte});
        bytes_wide     = (int'(width) + 7) / 8 * mluf_pkg::BITS_PER_PIXEL;
        line_len_now   = int'(bytes_wide[7:0]);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // mostly whole frames with random content; some clean starts, strays and cut frames
    task automatic random_frames(input int budget, input int max_span);
        int         roll;
        int         span;
        int         total;
        int         npix;
        logic [7:0] lo_a;
        logic [7:0] lo_b;
        logic [7:0] t;
        logic [7:0] b;
        logic [7:0] l;
        logic [7:0] r;
        items_sent = 0;
        while (items_sent < budget) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                send_start(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                repeat ($urandom_range(0, 2)) send_pixel(8'($urandom), 1'b0);
            end else begin
                span = (roll < 25) ? $urandom_range(0, max_span)
                                   : $urandom_range(0, (max_span < 2) ? max_span : 2);
                lo_a = 8'($urandom_range(0, 255 - span));
                lo_b = 8'($urandom_range(0, 255 - span));
                // random order of the bounds in both pairs
                if ($urandom_range(1)) begin
                    t = lo_a;
                    b = lo_a + 8'(span);
                end else begin
                    t = lo_a + 8'(span);
                    b = lo_a;
                end
                if ($urandom_range(1)) begin
                    l = lo_b;
                    r = lo_b + 8'(span);
                end else begin
                    l = lo_b + 8'(span);
                    r = lo_b;
                end
                total = (span + 1) * line_len_now;
                npix  = ($urandom_range(99) < 12) ? $urandom_range(0, total) : total;
                send_start(1'b1, t, b, l, r);
                repeat (npix) send_pixel(8'($urandom), 1'b1);
                if (line_len_now == 0 || (npix == total && $urandom_range(99) < 8))
                    send_pixel(8'($urandom), 1'b0);
            end
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one byte per line, line number wrap, bound order, start inside a frame
        set_mode(mluf_pkg::ROT_0, 11'd1, 8'hFF, 0, 0);
        send_pixel(8'hFF, 1'b0);
        send_start(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_start(1'b1, 8'd255, 8'd254, 8'd0, 8'd0);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'hA5, 1'b0);
        send_start(1'b1, 8'd0, 8'd0, 8'd255, 8'd255);
        send_pixel(8'h01, 1'b1);
        send_start(1'b1, 8'd0, 8'd255, 8'd255, 8'd0);
        send_pixel(8'h80, 1'b1);
        send_start(1'b1, 8'd10, 8'd12, 8'd0, 8'd0);
        send_pixel(8'h7E, 1'b1);
        send_start(1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'h55, 1'b0);

        // directed: bytes per line wraps to zero
        set_mode(mluf_pkg::ROT_270, 11'd2047, 8'h00, 0, 0);
        send_start(1'b1, 8'd3, 8'd9, 8'd200, 8'd100);
        send_pixel(8'hC3, 1'b0);

        // full window of one-byte lines, cut after the first few
        set_mode(mluf_pkg::ROT_0, 11'd8, 8'h88, 0, 0);
        send_start(1'b1, 8'd0, 8'd255, 8'($urandom), 8'($urandom));
        repeat (10) send_pixel(8'($urandom), 1'b1);
        random_frames(20, 7);

        set_mode(mluf_pkg::ROT_90, 11'd20, 8'hFF, 88, 0);
        random_frames(20, 7);

        set_mode(mluf_pkg::ROT_180, 11'd1, 8'h00, 0, 88);
        random_frames(20, 7);

        set_mode(mluf_pkg::ROT_270, 11'd24, 8'h5A, 6, 6);
        random_frames(20, 7);

        // widest panel: 255-byte lines, cut frames
        set_mode(mluf_pkg::ROT_180, 11'd2040, 8'hA5, 0, 0);
        send_start(1'b1, 8'd7, 8'd7, 8'($urandom), 8'($urandom));
        repeat (16) send_pixel(8'($urandom), 1'b1);
        send_start(1'b1, 8'd1, 8'd0, 8'($urandom), 8'($urandom));
        repeat (8) send_pixel(8'($urandom), 1'b1);
        send_start(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));

        set_mode(mluf_pkg::ROT_90, 11'd2047, 8'h3C, 88, 88);
        random_frames(8, 7);

        // back-pressure: receiver holds off while the sender keeps offering
        set_mode(mluf_pkg::ROT_0, 11'd128, 8'hC0, 0, 0);
        holdoff_asked++;
        random_frames(20, 2);

        @(negedge i_clk);
        push <= 1'b0;
        while (results_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mluf_pkg.sv
src/mluf_queue.sv
src/mluf_front.sv
src/mluf_back.sv
src/memory_lcd_line_update_framer.sv
src/mluf_checker.sv
bench/lcd_frame_checker.sv
bench/memory_lcd_line_update_framer_test.sv
